/* rtl/hsfc_pkg.sv */
`default_nettype none

package hsfc_pkg;

	// conversion direction
	localparam logic FUNC_H2S = 1'b0;
	localparam logic FUNC_S2H = 1'b1;

	// operand class, shared by both directions (zero also covers tiny singles)
	typedef logic [1:0] cls_t;
	localparam cls_t CLS_ZERO = 2'd0;
	localparam cls_t CLS_SUB  = 2'd1;
	localparam cls_t CLS_NORM = 2'd2;
	localparam cls_t CLS_SPEC = 2'd3;

	// format constants
	localparam int          BIAS_DIFF      = 127 - 15;
	localparam logic [7:0]  BIAS_DIFF8     = 8'(BIAS_DIFF);
	localparam logic [7:0]  SGL_EXP_MAX    = 8'hff;
	localparam logic [4:0]  HLF_EXP_MAX    = 5'h1f;
	localparam logic [24:0] RND_HALF_M1    = 25'h0000fff;
	// smallest single exponent that does not round to zero in half
	localparam logic [7:0]  SGL_EXP_TINY   = 8'(BIAS_DIFF - 10);
	// subnormal shift is 14 - (e - BIAS_DIFF)
	localparam logic [7:0]  SUB_SHIFT_BASE = 8'(BIAS_DIFF + 14);
	localparam logic [7:0]  HLF_EXP_LIMIT  = 8'd30;

endpackage

`default_nettype wire

/* rtl/half_single_float_converter_top.sv */
// Channel   Dir  Signals                 Handshake
// ------    ---  ----------------------  ---------------------------------------
// command   in   func, operand           word taken on clk rise when start & !busy
// result    out  result                  word valid for one cycle while done high
//
// Three-stage pipeline: decode and leading-zero count, then the rounding add
// or normalize shift, then the final right shift and pack. An accepted word
// passes the stage 1, 2 and 3 registers to done; one word can enter every cycle.
// busy is always low since no stage ever waits. Reset clears the valid bits
// only. The receiver cannot stall, so results leave as soon as they are done.
`default_nettype none

module half_single_float_converter_top
	import hsfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [31:0] operand,
	output logic             done,
	output logic [31:0]      result
);

	// stage 1 registers
	logic        v_s1;
	logic        func_s1;
	logic        sign_s1;
	cls_t        cls_s1;
	logic [31:0] opnd_s1;
	logic [3:0]  lz_s1;
	logic [4:0]  t_s1;

	// stage 2 registers
	logic        v_s2;
	logic        func_s2;
	logic        sign_s2;
	cls_t        cls_s2;
	logic [7:0]  exp_s2;
	logic [9:0]  frac_s2;
	logic        nz_s2;
	logic [24:0] sum_s2;
	logic [4:0]  t_s2;

	// stage 3 registers
	logic        v_s3;
	logic        func_s3;
	cls_t        cls_s3;
	logic [31:0] res_s3;

	assign busy = 1'b0;

	// ---------------- stage 1: classify, count leading zeros ----------------
	logic       acc;
	logic [4:0] h_exp;
	logic [9:0] h_frac;
	logic [7:0] s_exp;
	cls_t       cls_d1;
	logic [3:0] lz_d1;

	assign acc    = start && !busy;
	assign h_exp  = operand[14:10];
	assign h_frac = operand[9:0];
	assign s_exp  = operand[30:23];

	always_comb begin
		// highest set bit wins
		lz_d1 = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (h_frac[i]) begin
				lz_d1 = 4'(9 - i);
			end
		end
		if (func == FUNC_H2S) begin
			if (h_exp == 5'd0) begin
				cls_d1 = (h_frac == 10'd0) ? CLS_ZERO : CLS_SUB;
			end else if (h_exp == HLF_EXP_MAX) begin
				cls_d1 = CLS_SPEC;
			end else begin
				cls_d1 = CLS_NORM;
			end
		end else begin
			if (s_exp < SGL_EXP_TINY) begin
				cls_d1 = CLS_ZERO;
			end else if (s_exp <= BIAS_DIFF8) begin
				cls_d1 = CLS_SUB;
			end else if (s_exp == SGL_EXP_MAX) begin
				cls_d1 = CLS_SPEC;
			end else begin
				cls_d1 = CLS_NORM;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		sign_s1 <= (func == FUNC_H2S) ? operand[15] : operand[31];
		cls_s1  <= cls_d1;
		opnd_s1 <= operand;
		lz_s1   <= lz_d1;
		t_s1    <= 5'(SUB_SHIFT_BASE - s_exp);
	end

	// ---------------- stage 2: rounding add / normalize shift ----------------
	logic [24:0] fr25;
	logic [24:0] bias;
	logic        odd;
	logic [24:0] addend;
	logic [7:0]  exp_d2;
	logic [9:0]  frac_d2;
	logic [9:0]  h_norm;

	assign fr25   = {2'b01, opnd_s1[22:0]};
	assign bias   = (25'd1 << (t_s1 - 5'd1)) - 25'd1;
	assign odd    = fr25[t_s1];
	assign h_norm = opnd_s1[9:0] << (lz_s1 + 4'd1);

	always_comb begin
		if (cls_s1 == CLS_SUB) begin
			addend = bias + {24'd0, odd};
		end else begin
			addend = RND_HALF_M1 + {24'd0, opnd_s1[13]};
		end
		exp_d2  = 8'd0;
		frac_d2 = opnd_s1[9:0];
		if (func_s1 == FUNC_H2S) begin
			case (cls_s1)
				CLS_ZERO: exp_d2 = 8'd0;
				CLS_SUB: begin
					exp_d2  = BIAS_DIFF8 - {4'd0, lz_s1};
					frac_d2 = h_norm;
				end
				CLS_NORM: exp_d2 = {3'd0, opnd_s1[14:10]} + BIAS_DIFF8;
				default:  exp_d2 = SGL_EXP_MAX;
			endcase
		end else begin
			exp_d2  = opnd_s1[30:23] - BIAS_DIFF8;
			frac_d2 = opnd_s1[22:13];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		sign_s2 <= sign_s1;
		cls_s2  <= cls_s1;
		exp_s2  <= exp_d2;
		frac_s2 <= frac_d2;
		nz_s2   <= (opnd_s1[22:0] != 23'd0);
		sum_s2  <= ((cls_s1 == CLS_SUB) ? fr25 : {2'b00, opnd_s1[22:0]}) + addend;
		t_s2    <= t_s1;
	end

	// ---------------- stage 3: final shift and pack ----------------
	logic [24:0] sub_q;
	logic [7:0]  ex_adj;
	logic [31:0] res_d3;

	assign sub_q  = sum_s2 >> t_s2;
	assign ex_adj = exp_s2 + {7'd0, sum_s2[23]};

	always_comb begin
		res_d3 = 32'd0;
		if (func_s2 == FUNC_H2S) begin
			res_d3 = {sign_s2, exp_s2, frac_s2, 13'd0};
		end else begin
			case (cls_s2)
				CLS_ZERO: res_d3 = {16'd0, sign_s2, 15'd0};
				CLS_SUB:  res_d3 = {16'd0, sign_s2, 4'd0, sub_q[10:0]};
				CLS_SPEC: begin
					if (!nz_s2) begin
						res_d3 = {16'd0, sign_s2, HLF_EXP_MAX, 10'd0};
					end else begin
						// keep top payload, force a set bit so it stays a NaN
						res_d3 = {16'd0, sign_s2, HLF_EXP_MAX,
							frac_s2[9:1], frac_s2[0] | (frac_s2 == 10'd0)};
					end
				end
				default: begin
					if (ex_adj > HLF_EXP_LIMIT) begin
						res_d3 = {16'd0, sign_s2, HLF_EXP_MAX, 10'd0};
					end else if (sum_s2[23]) begin
						res_d3 = {16'd0, sign_s2, ex_adj[4:0], 10'd0};
					end else begin
						res_d3 = {16'd0, sign_s2, ex_adj[4:0], sum_s2[22:13]};
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		func_s3 <= func_s2;
		cls_s3  <= cls_s2;
		res_s3  <= res_d3;
	end

	assign done   = v_s3;
	assign result = res_s3;

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("accepted word did not complete in three cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result strobe without a matching command");

	a_half_upper: assert property (@(posedge clk) disable iff (!arst_n)
		done && func_s3 == FUNC_S2H |-> result[31:16] == 16'd0)
		else $error("half result has nonzero upper bits");

	a_sub_exp: assert property (@(posedge clk) disable iff (!arst_n)
		done && func_s3 == FUNC_H2S && cls_s3 == CLS_SUB |->
			result[30:23] >= 8'd103 && result[30:23] <= BIAS_DIFF8)
		else $error("renormalized subnormal exponent out of range");

endmodule

`default_nettype wire
